// ===== hdl/irdec_pkg.sv =====
// ----------------------------------------------------------------------------
// irdec_pkg
// Types, constants and helper functions of the IR remote frame decoder.
// ----------------------------------------------------------------------------
package irdec_pkg;

  localparam int unsigned FRAME_EDGES    = 34;
  localparam int unsigned CMD_FIRST_EDGE = 18;
  localparam int unsigned CMD_LAST_EDGE  = 25;
  localparam int unsigned LEADER_EDGE    = 2;
  localparam int unsigned KEY_COUNT      = 10;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned BOUND_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned REG_W   = 4;

  localparam logic [CMD_W-1:0] KEY_CODES [KEY_COUNT] = '{
    8'h68, 8'h30, 8'h18, 8'h7A, 8'h10, 8'h38, 8'h5A, 8'h42, 8'h4A, 8'h52
  };

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_MATCH   = 2'd1,
    EV_NOMATCH = 2'd2,
    EV_REPEAT  = 2'd3
  } event_kind_t;

  typedef enum logic [REG_W-1:0] {
    REG_LEADER_LOW  = 4'd0,
    REG_LEADER_HIGH = 4'd1,
    REG_REPEAT_LOW  = 4'd2,
    REG_REPEAT_HIGH = 4'd3,
    REG_ZERO_LOW    = 4'd4,
    REG_ZERO_HIGH   = 4'd5,
    REG_ONE_LOW     = 4'd6,
    REG_ONE_HIGH    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] edge_tick;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic [1:0]       event_kind;
    logic [CMD_W-1:0] command_byte;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0]   index;
    logic [BOUND_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [BOUND_W-1:0] leader_low;
    logic [BOUND_W-1:0] leader_high;
    logic [BOUND_W-1:0] repeat_low;
    logic [BOUND_W-1:0] repeat_high;
    logic [BOUND_W-1:0] zero_low;
    logic [BOUND_W-1:0] zero_high;
    logic [BOUND_W-1:0] one_low;
    logic [BOUND_W-1:0] one_high;
  } windows_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } key_lookup_t;

  function automatic logic in_window(logic [TICK_W-1:0] d, logic [BOUND_W-1:0] lo,
                                     logic [BOUND_W-1:0] hi);
    in_window = (d > TICK_W'(lo)) && (d < TICK_W'(hi));
  endfunction

  function automatic key_lookup_t key_lookup(logic [CMD_W-1:0] code);
    key_lookup_t r;
    r.hit = 1'b0;
    r.key = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (KEY_CODES[i] == code) begin
        r.hit = 1'b1;
        r.key = KEY_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/irdec_stream_if.sv =====
// ----------------------------------------------------------------------------
// irdec_stream_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface irdec_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/ir_remote_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ir_remote_frame_decoder_top
// NEC-style IR frame decoder: one result per falling-edge timestamp.
// ----------------------------------------------------------------------------
// A request is registered in the input register, then decoded into the result register.
// Throughput: 1 request per cycle while results are taken; an output stall holds the input.
// A stalled result holds in the result register while one more request waits.
// Reset (rst_n low, synchronous) clears the pipeline, frame state, keys and
// loads the default window bounds.
module ir_remote_frame_decoder_top (
  input logic          clk,
  input logic          rst_n,
  irdec_stream_if.sink   in_,
  irdec_stream_if.source out_,
  irdec_stream_if.sink   cfg_
);

  localparam int unsigned TW = irdec_pkg::TICK_W;
  localparam int unsigned IW = irdec_pkg::IDX_W;
  localparam int unsigned KW = irdec_pkg::KEY_W;
  localparam int unsigned CW = irdec_pkg::CMD_W;

  irdec_pkg::windows_t win;

  irdec_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_  (cfg_),
    .win   (win)
  );

  logic                  s1_v_r;
  logic [TW-1:0]         s1_tick_r;
  logic                  out_v_r;
  irdec_pkg::out_item_t  out_item_r;
  logic                  adv;

  logic [IW-1:0] edge_idx_r, edge_idx_nxt;
  logic [TW-1:0] last_us_r;
  logic [CW-1:0] cmd_r, cmd_nxt;
  logic [KW-1:0] last_key_r, last_key_nxt;
  logic [KW-1:0] cur_key_r, cur_key_nxt;
  irdec_pkg::event_kind_t ev_nxt;

  logic [TW-1:0] us;
  logic [TW-1:0] d;
  logic          measured;
  logic [IW-1:0] idx_inc;
  logic [2:0]    bit_pos;
  irdec_pkg::key_lookup_t lk;

  assign adv       = s1_v_r && (!out_v_r || out_.ready);
  assign in_.ready = !s1_v_r || adv;
  assign out_.valid   = out_v_r;
  assign out_.payload = out_item_r;

  assign us       = (s1_tick_r << 3) + (s1_tick_r << 1);
  assign d        = us - last_us_r;
  assign measured = edge_idx_r != '0;
  assign idx_inc  = edge_idx_r + IW'(1);
  assign bit_pos  = 3'(IW'(irdec_pkg::CMD_LAST_EDGE) - edge_idx_r);
  assign lk       = irdec_pkg::key_lookup(cmd_nxt);

  always_comb begin
    edge_idx_nxt = edge_idx_r;
    cmd_nxt      = cmd_r;
    last_key_nxt = last_key_r;
    cur_key_nxt  = cur_key_r;
    ev_nxt       = irdec_pkg::EV_NONE;
    if (measured && irdec_pkg::in_window(d, win.repeat_low, win.repeat_high)) begin
      cur_key_nxt  = last_key_r;
      edge_idx_nxt = '0;
      ev_nxt       = irdec_pkg::EV_REPEAT;
    end else begin
      if (measured && irdec_pkg::in_window(d, win.leader_low, win.leader_high)) begin
        edge_idx_nxt = IW'(irdec_pkg::LEADER_EDGE);
      end else begin
        if (edge_idx_r >= IW'(irdec_pkg::CMD_FIRST_EDGE) &&
            edge_idx_r <= IW'(irdec_pkg::CMD_LAST_EDGE) &&
            edge_idx_r < IW'(irdec_pkg::FRAME_EDGES)) begin
          if (irdec_pkg::in_window(d, win.zero_low, win.zero_high)) begin
            cmd_nxt[bit_pos] = 1'b0;
          end else if (irdec_pkg::in_window(d, win.one_low, win.one_high)) begin
            cmd_nxt[bit_pos] = 1'b1;
          end
        end
        edge_idx_nxt = idx_inc;
      end
      if (edge_idx_nxt == IW'(irdec_pkg::FRAME_EDGES)) begin
        edge_idx_nxt = '0;
        if (lk.hit) begin
          cur_key_nxt  = lk.key;
          last_key_nxt = lk.key;
          ev_nxt       = irdec_pkg::EV_MATCH;
        end else begin
          cur_key_nxt = '0;
          ev_nxt      = irdec_pkg::EV_NOMATCH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      edge_idx_r <= '0;
      last_us_r  <= '0;
      cmd_r      <= '0;
      last_key_r <= '0;
      cur_key_r  <= '0;
    end else begin
      if (in_.ready) begin
        s1_v_r <= in_.valid;
      end
      if (adv) begin
        out_v_r    <= 1'b1;
        edge_idx_r <= edge_idx_nxt;
        last_us_r  <= us;
        cmd_r      <= cmd_nxt;
        last_key_r <= last_key_nxt;
        cur_key_r  <= cur_key_nxt;
      end else if (out_.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_.valid && in_.ready) begin
      s1_tick_r <= in_.payload.edge_tick;
    end
    if (adv) begin
      out_item_r.key_value    <= cur_key_nxt;
      out_item_r.event_kind   <= ev_nxt;
      out_item_r.command_byte <= cmd_nxt;
    end
  end

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ev_nxt != irdec_pkg::EV_NONE) |=> edge_idx_r == '0)
    else $error("edge index not cleared after frame end or repeat");

  a_idx_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
    edge_idx_r != IW'(irdec_pkg::FRAME_EDGES))
    else $error("edge index reached frame length");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_key_r < KW'(irdec_pkg::KEY_COUNT) && last_key_r < KW'(irdec_pkg::KEY_COUNT))
    else $error("key out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== hdl/irdec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// irdec_cfg_regs
// Window bound registers of the IR frame decoder, written over the cfg channel.
// ----------------------------------------------------------------------------
module irdec_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  irdec_stream_if.sink        cfg_,
  output irdec_pkg::windows_t win
);

  irdec_pkg::windows_t win_r;

  assign cfg_.ready = 1'b1;
  assign win        = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.leader_low  <= 16'd13000;
      win_r.leader_high <= 16'd14000;
      win_r.repeat_low  <= 16'd11000;
      win_r.repeat_high <= 16'd12000;
      win_r.zero_low    <= 16'd1000;
      win_r.zero_high   <= 16'd1500;
      win_r.one_low     <= 16'd2000;
      win_r.one_high    <= 16'd2500;
    end else if (cfg_.valid) begin
      case (cfg_.payload.index)
        irdec_pkg::REG_LEADER_LOW:  win_r.leader_low  <= cfg_.payload.data;
        irdec_pkg::REG_LEADER_HIGH: win_r.leader_high <= cfg_.payload.data;
        irdec_pkg::REG_REPEAT_LOW:  win_r.repeat_low  <= cfg_.payload.data;
        irdec_pkg::REG_REPEAT_HIGH: win_r.repeat_high <= cfg_.payload.data;
        irdec_pkg::REG_ZERO_LOW:    win_r.zero_low    <= cfg_.payload.data;
        irdec_pkg::REG_ZERO_HIGH:   win_r.zero_high   <= cfg_.payload.data;
        irdec_pkg::REG_ONE_LOW:     win_r.one_low     <= cfg_.payload.data;
        irdec_pkg::REG_ONE_HIGH:    win_r.one_high    <= cfg_.payload.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR remote frame decoder. Feeds falling-edge
// timestamps built as leader/bit/repeat sequences, broken frames and noise,
// predicts every result in a cycle-free model of the decoder, and compares
// each result field by field under several window settings and flow-control
// mixes, including a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES = 400;

  localparam logic [7:0] REMOTE_CODES [10] = '{
    8'h68, 8'h30, 8'h18, 8'h7A, 8'h10, 8'h38, 8'h5A, 8'h42, 8'h4A, 8'h52
  };

  localparam irdec_pkg::windows_t RESET_BOUNDS = '{
    leader_low: 16'd13000, leader_high: 16'd14000,
    repeat_low: 16'd11000, repeat_high: 16'd12000,
    zero_low:   16'd1000,  zero_high:   16'd1500,
    one_low:    16'd2000,  one_high:    16'd2500
  };

  localparam irdec_pkg::windows_t OVERLAP_BOUNDS = '{
    leader_low: 16'd10000, leader_high: 16'd14000,
    repeat_low: 16'd11000, repeat_high: 16'd12000,
    zero_low:   16'd500,   zero_high:   16'd1800,
    one_low:    16'd1200,  one_high:    16'd2600
  };

  localparam irdec_pkg::windows_t EXTREME_BOUNDS = '{
    leader_low: 16'd65535, leader_high: 16'd0,
    repeat_low: 16'd0,     repeat_high: 16'd0,
    zero_low:   16'd0,     zero_high:   16'd1000,
    one_low:    16'd1000,  one_high:    16'd65535
  };

  logic clk = 1'b0;
  logic rst_n;

  irdec_stream_if #(.payload_t(irdec_pkg::in_item_t))  in_if ();
  irdec_stream_if #(.payload_t(irdec_pkg::out_item_t)) out_if ();
  irdec_stream_if #(.payload_t(irdec_pkg::cfg_req_t))  cfg_if ();

  ir_remote_frame_decoder_top dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_  (in_if),
    .out_ (out_if),
    .cfg_ (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder model state
  irdec_pkg::windows_t bounds       = RESET_BOUNDS;
  logic [5:0]          frame_edge   = '0;
  logic [31:0]         prev_edge_us = '0;
  logic [7:0]          cmd_reg      = '0;
  logic [3:0]          saved_key    = '0;
  logic [3:0]          shown_key    = '0;

  logic [31:0]          tick_queue [$];
  irdec_pkg::out_item_t expected_decodes [$];
  logic [31:0] stamp = '0;
  int unsigned queued_edges = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_trigger = 1'b0;
  logic        long_hold = 1'b0;

  function automatic logic fits(logic [31:0] span, logic [15:0] lo, logic [15:0] hi);
    return (span > {16'd0, lo}) && (span < {16'd0, hi});
  endfunction

  function automatic irdec_pkg::out_item_t decode_edge(logic [31:0] tick);
    irdec_pkg::out_item_t   r;
    logic [31:0]            now_us;
    logic [31:0]            span;
    logic                   timed;
    logic                   hit;
    irdec_pkg::event_kind_t kind;
    now_us = tick * 32'd10;
    timed = (frame_edge != 0);
    span = now_us - prev_edge_us;
    prev_edge_us = now_us;
    kind = irdec_pkg::EV_NONE;
    if (timed && fits(span, bounds.repeat_low, bounds.repeat_high)) begin
      shown_key = saved_key;
      frame_edge = '0;
      kind = irdec_pkg::EV_REPEAT;
    end else begin
      if (timed && fits(span, bounds.leader_low, bounds.leader_high)) begin
        frame_edge = 6'(irdec_pkg::LEADER_EDGE);
      end else begin
        if (frame_edge >= irdec_pkg::CMD_FIRST_EDGE &&
            frame_edge <= irdec_pkg::CMD_LAST_EDGE) begin
          if (fits(span, bounds.zero_low, bounds.zero_high)) begin
            cmd_reg[irdec_pkg::CMD_LAST_EDGE - frame_edge] = 1'b0;
          end else if (fits(span, bounds.one_low, bounds.one_high)) begin
            cmd_reg[irdec_pkg::CMD_LAST_EDGE - frame_edge] = 1'b1;
          end
        end
        frame_edge = frame_edge + 6'd1;
      end
      if (frame_edge == irdec_pkg::FRAME_EDGES) begin
        frame_edge = '0;
        hit = 1'b0;
        for (int i = 0; i < 10; i++) begin
          if (!hit && REMOTE_CODES[i] == cmd_reg) begin
            hit = 1'b1;
            shown_key = 4'(i);
            saved_key = 4'(i);
          end
        end
        if (hit) begin
          kind = irdec_pkg::EV_MATCH;
        end else begin
          shown_key = '0;
          kind = irdec_pkg::EV_NOMATCH;
        end
      end
    end
    r.key_value = shown_key;
    r.event_kind = kind;
    r.command_byte = cmd_reg;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_decodes.push_back(decode_edge(in_if.payload.edge_tick));
      end
      if (!in_if.valid || in_if.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.payload.edge_tick <= tick_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    irdec_pkg::out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_decodes.size() == 0) begin
          $error("unexpected result: key_value %0d event_kind %0d command_byte %02h",
                 out_if.payload.key_value, out_if.payload.event_kind,
                 out_if.payload.command_byte);
          mismatches++;
        end else begin
          want = expected_decodes.pop_front();
          if (out_if.payload.key_value !== want.key_value) begin
            $error("key_value: expected %0d, got %0d", want.key_value,
                   out_if.payload.key_value);
            mismatches++;
          end
          if (out_if.payload.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind,
                   out_if.payload.event_kind);
            mismatches++;
          end
          if (out_if.payload.command_byte !== want.command_byte) begin
            $error("command_byte: expected %02h, got %02h", want.command_byte,
                   out_if.payload.command_byte);
            mismatches++;
          end
        end
      end
      out_if.ready <= !long_hold && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    while (!hold_trigger) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic emit_edge(input logic [31:0] gap);
    stamp = stamp + gap;
    tick_queue.push_back(stamp);
    queued_edges++;
  endtask

  function automatic logic [31:0] window_gap(logic [15:0] lo, logic [15:0] hi);
    int unsigned first;
    int unsigned last;
    first = lo / 10 + 1;
    last = (hi == 0) ? 0 : (hi - 1) / 10;
    if (hi > lo && first <= last) begin
      return $urandom_range(last, first);
    end
    return $urandom_range(6553, 0);
  endfunction

  task automatic queue_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned nbits;
    logic [7:0]  code;
    logic        b;
    goal = queued_edges + count;
    while (queued_edges < goal) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        if ($urandom_range(9, 0) == 0) begin
          stamp = $urandom_range(1, 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(30000, 0);
        end
        code = ($urandom_range(9, 0) < 6) ? REMOTE_CODES[$urandom_range(9, 0)] : 8'($urandom);
        nbits = (pick < 68) ? 32 : $urandom_range(31, 0);
        emit_edge($urandom_range(20000, 1));
        emit_edge(window_gap(bounds.leader_low, bounds.leader_high));
        for (int k = 0; k < nbits; k++) begin
          b = (k >= 16 && k < 24) ? code[23 - k] : 1'($urandom);
          if ($urandom_range(9, 0) == 0) begin
            emit_edge($urandom_range(400, 0));
          end else if (b) begin
            emit_edge(window_gap(bounds.one_low, bounds.one_high));
          end else begin
            emit_edge(window_gap(bounds.zero_low, bounds.zero_high));
          end
        end
      end else if (pick < 92) begin
        emit_edge($urandom_range(20000, 1));
        emit_edge(window_gap(bounds.repeat_low, bounds.repeat_high));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          emit_edge($urandom_range(1, 0) ? $urandom : $urandom_range(7000, 0));
        end
      end
    end
  endtask

  task automatic write_window(input irdec_pkg::cfg_reg_t which, input logic [15:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.payload.index <= which;
    cfg_if.payload.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (which)
      irdec_pkg::REG_LEADER_LOW:  bounds.leader_low = value;
      irdec_pkg::REG_LEADER_HIGH: bounds.leader_high = value;
      irdec_pkg::REG_REPEAT_LOW:  bounds.repeat_low = value;
      irdec_pkg::REG_REPEAT_HIGH: bounds.repeat_high = value;
      irdec_pkg::REG_ZERO_LOW:    bounds.zero_low = value;
      irdec_pkg::REG_ZERO_HIGH:   bounds.zero_high = value;
      irdec_pkg::REG_ONE_LOW:     bounds.one_low = value;
      irdec_pkg::REG_ONE_HIGH:    bounds.one_high = value;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_windows(input irdec_pkg::windows_t w);
    write_window(irdec_pkg::REG_LEADER_LOW, w.leader_low);
    write_window(irdec_pkg::REG_LEADER_HIGH, w.leader_high);
    write_window(irdec_pkg::REG_REPEAT_LOW, w.repeat_low);
    write_window(irdec_pkg::REG_REPEAT_HIGH, w.repeat_high);
    write_window(irdec_pkg::REG_ZERO_LOW, w.zero_low);
    write_window(irdec_pkg::REG_ZERO_HIGH, w.zero_high);
    write_window(irdec_pkg::REG_ONE_LOW, w.one_low);
    write_window(irdec_pkg::REG_ONE_HIGH, w.one_high);
  endtask

  task automatic settle();
    while (tick_queue.size() != 0 || in_if.valid || expected_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    irdec_pkg::windows_t scrambled;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, wrap, window boundaries, repeat and leader
    emit_edge(32'd0);
    emit_edge(32'hFFFF_FFFF);
    emit_edge(32'd1150);
    emit_edge(32'd7);
    emit_edge(32'd1350);
    emit_edge(32'd1100);
    emit_edge(32'd1200);
    emit_edge(32'd1300);
    emit_edge(32'd1400);
    emit_edge(32'd1199);
    emit_edge(32'd3);
    emit_edge(32'd1301);
    emit_edge(32'd0);
    emit_edge(32'd100);
    emit_edge(32'd150);
    emit_edge(32'd200);
    emit_edge(32'd250);
    emit_edge(32'd125);
    emit_edge(32'd225);
    emit_edge(32'd1151);
    settle();

    load_windows(RESET_BOUNDS);
    queue_traffic(350);
    settle();

    load_windows(OVERLAP_BOUNDS);
    send_idle_pct = 80;
    queue_traffic(300);
    settle();

    load_windows(EXTREME_BOUNDS);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    queue_traffic(250);
    settle();

    scrambled = irdec_pkg::windows_t'({$urandom, $urandom, $urandom, $urandom});
    load_windows(scrambled);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    queue_traffic(250);
    settle();

    // hold the output while the sender keeps offering
    load_windows(RESET_BOUNDS);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trigger = 1'b1;
    queue_traffic(200);
    settle();

    send_idle_pct = 6;
    recv_stall_pct = 6;
    queue_traffic(200);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/irdec_pkg.sv
hdl/irdec_stream_if.sv
hdl/irdec_cfg_regs.sv
hdl/ir_remote_frame_decoder_top.sv
test/tb.sv
